/* hdl/htc_pkg.sv */
// ----------------------------------------------------------------------------
// htc_pkg
// shared types, codes and constants of the heater thermostat controller
// ----------------------------------------------------------------------------
package htc_pkg;

    // beat commands
    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_ON   = 2'd1;
    localparam logic [1:0] CMD_OFF  = 2'd2;

    // reported mode
    localparam logic [1:0] MODE_OFF  = 2'd0;
    localparam logic [1:0] MODE_ON   = 2'd1;
    localparam logic [1:0] MODE_COOL = 2'd2;

    // register indexes (byte address is 4 times the index)
    localparam logic [1:0] REG_SETPOINT   = 2'd0;
    localparam logic [1:0] REG_HYSTERESIS = 2'd1;
    localparam logic [1:0] REG_TURBO      = 2'd2;

    localparam int ADDR_W = 4;

    // reset values of the registers
    localparam logic [11:0] SETPOINT_RST   = 12'd0;
    localparam logic [7:0]  HYSTERESIS_RST = 8'd2;

    // fan duties and cooldown count
    localparam logic [7:0] FAN_OFF    = 8'd0;
    localparam logic [7:0] FAN_SILENT = 8'd100;
    localparam logic [7:0] FAN_TURBO  = 8'd255;
    localparam int COOLDOWN_COUNT = 5;   // loaded by the external timer on load_timer

    // field widths
    localparam int ADC_W    = 10;
    localparam int REMAIN_W = 16;
    localparam int TENTHS_W = 12;

    // floor(x*1024/450) == (x * SCALE_MUL) >> SCALE_SHIFT, exact for every 10-bit x
    localparam int SCALE_SHIFT = 20;
    localparam logic [21:0] SCALE_MUL = 22'd2386093;
    localparam int PROD_W = ADC_W + 22;

    // averaging ring, depth a power of two so the mean is a shift
    localparam int AVG_SHIFT = 3;
    localparam int AVG_DEPTH = 1 << AVG_SHIFT;
    localparam int IDX_W = (AVG_SHIFT > 0) ? AVG_SHIFT : 1;
    localparam int SUM_W = TENTHS_W + AVG_SHIFT;

    typedef struct packed {
        logic [1:0]          cmd;
        logic [TENTHS_W-1:0] scaled;
        logic [REMAIN_W-1:0] remaining;
    } t_item;

    typedef struct packed {
        logic [11:0] setpoint;
        logic [7:0]  hysteresis;
        logic        turbo;
    } t_cfg;

    typedef struct packed {
        logic [TENTHS_W-1:0] avg_tenths;
        logic                load_timer;
        logic [1:0]          mode_status;
        logic                heating;
        logic [7:0]          fan_duty;
        logic                heat_relays;
    } t_result;

endpackage

/* hdl/htc_core.sv */
// ----------------------------------------------------------------------------
// htc_core
// thermostat state, averaging ring and heat / fan decision for one beat
// ----------------------------------------------------------------------------
module htc_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,    // beat leaves the input register
    input  htc_pkg::t_item   i_item,
    input  htc_pkg::t_cfg    i_cfg,
    output htc_pkg::t_result o_res      // result of i_item, valid with i_step
);

    logic [htc_pkg::TENTHS_W-1:0] r_ring [htc_pkg::AVG_DEPTH];
    logic [htc_pkg::IDX_W-1:0]    r_idx;
    logic [htc_pkg::SUM_W-1:0]    r_sum;
    logic                         r_on;
    logic                         r_attached;
    logic                         r_cool;
    logic                         r_heat;
    logic [7:0]                   r_fan;

    logic [htc_pkg::IDX_W-1:0]    n_idx;
    logic [htc_pkg::SUM_W-1:0]    n_sum;
    logic                         n_on;
    logic                         n_attached;
    logic                         n_cool;
    logic                         n_heat;
    logic [7:0]                   n_fan;
    logic                         n_load;

    logic                         w_tick;
    logic [htc_pkg::SUM_W-1:0]    w_tick_sum;
    logic [htc_pkg::TENTHS_W-1:0] w_avg;
    logic                         w_expired;
    logic                         w_above;
    logic                         w_below;
    logic signed [13:0]           w_lowmark;

    assign w_tick     = (i_item.cmd == htc_pkg::CMD_TICK);
    assign w_tick_sum = r_sum - htc_pkg::SUM_W'(r_ring[r_idx])
                      + htc_pkg::SUM_W'(i_item.scaled);
    assign w_expired  = (i_item.remaining == '0);

    // mean of the ring after this beat
    assign n_sum = w_tick ? w_tick_sum : r_sum;
    assign w_avg = htc_pkg::TENTHS_W'(n_sum >> htc_pkg::AVG_SHIFT);

    // setpoint minus hysteresis may go below zero
    assign w_lowmark = $signed({2'b00, i_cfg.setpoint}) - $signed({6'b0, i_cfg.hysteresis});
    assign w_above   = (w_avg > i_cfg.setpoint);
    assign w_below   = ($signed({2'b00, w_avg}) <= w_lowmark);

    always_comb begin
        n_idx      = r_idx;
        n_on       = r_on;
        n_attached = r_attached;
        n_cool     = r_cool;
        n_heat     = r_heat;
        n_fan      = r_fan;
        n_load     = 1'b0;
        case (i_item.cmd)
            htc_pkg::CMD_TICK: begin
                n_idx = r_idx + 1'b1;
                if (r_attached) begin
                    if (r_cool && w_expired) begin
                        n_fan  = htc_pkg::FAN_OFF;
                        n_cool = 1'b0;
                    end else if (r_on && w_expired) begin
                        n_heat = 1'b0;
                        n_on   = 1'b0;
                        n_cool = 1'b1;
                        n_load = 1'b1;
                    end else if (r_on) begin
                        if (w_above) begin
                            n_heat = 1'b0;
                            n_fan  = htc_pkg::FAN_SILENT;
                        end else if (w_below) begin
                            n_heat = 1'b1;
                            n_fan  = i_cfg.turbo ? htc_pkg::FAN_TURBO : htc_pkg::FAN_SILENT;
                        end
                    end
                end
            end
            htc_pkg::CMD_ON: begin
                n_on       = 1'b1;
                n_attached = 1'b1;
                n_cool     = 1'b0;
            end
            htc_pkg::CMD_OFF: begin
                n_heat = 1'b0;
                n_on   = 1'b0;
                n_cool = 1'b1;
                n_load = 1'b1;
            end
            default: begin
                // unused code: state holds
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < htc_pkg::AVG_DEPTH; i++) begin
                r_ring[i] <= '0;
            end
            r_idx      <= '0;
            r_sum      <= '0;
            r_on       <= 1'b0;
            r_attached <= 1'b0;
            r_cool     <= 1'b0;
            r_heat     <= 1'b0;
            r_fan      <= htc_pkg::FAN_OFF;
        end else if (i_step) begin
            if (w_tick) begin
                r_ring[r_idx] <= i_item.scaled;
            end
            r_idx      <= n_idx;
            r_sum      <= n_sum;
            r_on       <= n_on;
            r_attached <= n_attached;
            r_cool     <= n_cool;
            r_heat     <= n_heat;
            r_fan      <= n_fan;
        end
    end

    always_comb begin
        o_res.heat_relays = n_heat;
        o_res.fan_duty    = n_fan;
        o_res.heating     = n_heat;
        o_res.mode_status = n_on ? htc_pkg::MODE_ON :
                            (n_cool ? htc_pkg::MODE_COOL : htc_pkg::MODE_OFF);
        o_res.load_timer  = n_load;
        o_res.avg_tenths  = w_avg;
    end

endmodule

/* hdl/heater_thermostat_controller.sv */
// ----------------------------------------------------------------------------
// heater_thermostat_controller
// bang-bang heater thermostat with hysteresis, run timer and fan cooldown
// ----------------------------------------------------------------------------
//  channel   dir   handshake                     payload
//  s stream  in    i_s_tvalid / o_s_tready       tdata: adc_sample, timer_remaining
//                                                tuser: cmd
//  m stream  out   o_m_tvalid / i_m_tready       tdata: heat_relays .. avg_tenths
//  apb       in    psel, penable, pwrite, pready paddr, pwdata, prdata
//
//  one result beat per input beat, one beat per cycle sustained while the
//  receiver takes every beat: scaling multiply into the input register,
//  decision into the output register
//  synchronous active-low reset clears thermostat state, the sample ring and
//  both valid flags; registers return to setpoint 0, hysteresis 2, turbo off
//  a stalled output holds its beat while the input register still takes one
//  more beat; the input side stalls only when both stages are full
// ----------------------------------------------------------------------------
module heater_thermostat_controller (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input stream
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [31:0]                 i_s_tdata,   // [9:0] adc_sample, [25:10] timer_remaining
    input  logic [1:0]                  i_s_tuser,   // [1:0] cmd
    // output stream
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [31:0]                 o_m_tdata,   // [0] heat_relays, [8:1] fan_duty,
                                                     // [9] heating, [11:10] mode_status,
                                                     // [12] load_timer, [24:13] avg_tenths
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [htc_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    // configuration registers
    htc_pkg::t_cfg                r_cfg;
    logic                         w_cfg_wr;
    logic [1:0]                   w_reg_idx;

    // input register
    logic                         r_in_valid;
    htc_pkg::t_item               r_in;
    logic [htc_pkg::PROD_W-1:0]   w_prod;

    // output register
    logic                         r_out_valid;
    htc_pkg::t_result             r_res;
    htc_pkg::t_result             w_res;

    logic                         w_step;
    logic                         w_in_take;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[3:2];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.setpoint   <= htc_pkg::SETPOINT_RST;
            r_cfg.hysteresis <= htc_pkg::HYSTERESIS_RST;
            r_cfg.turbo      <= 1'b0;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                htc_pkg::REG_SETPOINT:   r_cfg.setpoint   <= pwdata[11:0];
                htc_pkg::REG_HYSTERESIS: r_cfg.hysteresis <= pwdata[7:0];
                htc_pkg::REG_TURBO:      r_cfg.turbo      <= pwdata[0];
                default: begin
                    // no register there
                end
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            htc_pkg::REG_SETPOINT:   prdata = {20'd0, r_cfg.setpoint};
            htc_pkg::REG_HYSTERESIS: prdata = {24'd0, r_cfg.hysteresis};
            htc_pkg::REG_TURBO:      prdata = {31'd0, r_cfg.turbo};
            default:                 prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    // the input register moves on when the output register is free or draining
    assign w_step     = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_step;
    assign w_in_take  = i_s_tvalid && o_s_tready;

    // ---------------- stage 1: capture and scale ----------------
    // raw converter reading to tenths of a degree by reciprocal multiply
    assign w_prod = htc_pkg::PROD_W'(i_s_tdata[htc_pkg::ADC_W-1:0]) *
                    htc_pkg::PROD_W'(htc_pkg::SCALE_MUL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in.cmd       <= i_s_tuser;
            r_in.scaled    <= w_prod[htc_pkg::SCALE_SHIFT +: htc_pkg::TENTHS_W];
            r_in.remaining <= i_s_tdata[htc_pkg::ADC_W +: htc_pkg::REMAIN_W];
        end
    end

    // ---------------- stage 2: thermostat decision ----------------
    htc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_item  (r_in),
        .i_cfg   (r_cfg),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_res <= w_res;
        end
    end

    // ---------------- output beat ----------------
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0,
                         r_res.avg_tenths,
                         r_res.load_timer,
                         r_res.mode_status,
                         r_res.heating,
                         r_res.fan_duty,
                         r_res.heat_relays};

    // ---------------- checks ----------------
    // a cooldown load request always comes with the cooldown mode
    a_load_in_cool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_res.load_timer) |-> (r_res.mode_status == htc_pkg::MODE_COOL))
        else $error("load_timer raised outside cooldown");

    // the relays never drive while the heater is switched off
    a_no_heat_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (r_res.mode_status != htc_pkg::MODE_ON)) |-> !r_res.heat_relays)
        else $error("relays on while not switched on");

    // fan duty is only ever one of the three levels
    a_fan_levels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ((r_res.fan_duty == htc_pkg::FAN_OFF) ||
                        (r_res.fan_duty == htc_pkg::FAN_SILENT) ||
                        (r_res.fan_duty == htc_pkg::FAN_TURBO)))
        else $error("fan duty out of set");

    // a beat enters the output register only from a full input register
    a_out_from_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$past(r_in_valid) && $past(i_rst_n)) |-> !(r_out_valid && !$past(r_out_valid)))
        else $error("result beat without a source beat");

endmodule

/* dv/tb_heater_thermostat_controller.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_heater_thermostat_controller
// self-checking bench for the heater thermostat controller
// ----------------------------------------------------------------------------
// every accepted input beat is run through a behavioral thermostat model
// (sample ring, running average, bang-bang rule with hysteresis, run timer
// expiry and fan cooldown); its reading, or the one typed into a directed
// row, is queued; each output beat is compared field by field with the head.
// a short directed table covers the corner cases, then randomized phases with
// different register settings and different amounts of idling on both sides.
// ----------------------------------------------------------------------------
module tb_heater_thermostat_controller;

    localparam logic [1:0] CMD_SPARE   = 2'd3;   // unused command code, ignored by the block
    localparam int         HOLD_CYCLES = 60;     // long receiver hold-off
    localparam int         PHASES      = 8;
    localparam int         PHASE_BEATS = 135;
    localparam int         DIR_ROWS    = 28;

    typedef enum logic {ROW_BEAT, ROW_REG} t_row_kind;

    // directed row: for ROW_BEAT code is the command and value the adc sample,
    // for ROW_REG code is the register index and value what gets written
    typedef struct {
        t_row_kind        kind;
        logic [1:0]       code;
        logic [31:0]      value;
        logic [15:0]      remain;
        bit               typed;
        htc_pkg::t_result want;
    } t_plan_row;

    // ------------------------------------------------------------------------
    // clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------------
    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic [31:0] i_s_tdata  = '0;
    logic [1:0]  i_s_tuser  = htc_pkg::CMD_TICK;
    logic        i_m_tready = 1'b0;
    logic        psel       = 1'b0;
    logic        penable    = 1'b0;
    logic        pwrite     = 1'b0;
    logic [htc_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata     = '0;

    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [31:0] o_m_tdata;
    logic [31:0] prdata;
    logic        pready;

    always #6 i_clk = ~i_clk;

    heater_thermostat_controller DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),    // [9:0] adc_sample, [25:10] timer_remaining
        .i_s_tuser  (i_s_tuser),    // [1:0] cmd
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),    // [0] heat_relays, [8:1] fan_duty, [9] heating,
                                    // [11:10] mode_status, [12] load_timer, [24:13] avg_tenths
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // ------------------------------------------------------------------------
    // thermostat model state, starts out as the block does after reset
    // ------------------------------------------------------------------------
    logic [htc_pkg::TENTHS_W-1:0] temp_ring [htc_pkg::AVG_DEPTH] = '{default: '0};
    logic [htc_pkg::IDX_W-1:0]    ring_pos       = '0;
    logic [htc_pkg::SUM_W-1:0]    ring_sum       = '0;
    logic                         switched_on    = 1'b0;
    logic                         timer_attached = 1'b0;
    logic                         cooling_down   = 1'b0;
    logic                         heat_state     = 1'b0;
    logic [7:0]                   fan_level      = htc_pkg::FAN_OFF;

    // register copies
    logic [11:0] cfg_setpoint = htc_pkg::SETPOINT_RST;
    logic [7:0]  cfg_hyst     = htc_pkg::HYSTERESIS_RST;
    logic        cfg_turbo    = 1'b0;

    htc_pkg::t_result readings_due [$];     // predicted readings not yet seen on the output
    int               mismatch_cnt = 0;

    // idling knobs, percent of cycles
    int src_idle_pct  = 0;
    int snk_stall_pct = 0;

    // receiver hold-off request: a toggle, so only the sink process counts
    logic hold_go   = 1'b0;
    logic hold_seen = 1'b0;
    int   hold_left = 0;

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        mismatch_cnt++;
    endtask

    function automatic htc_pkg::t_result reading(input logic heat, input logic [7:0] fan,
                                                 input logic [1:0] mode, input logic load,
                                                 input logic [11:0] avg);
        htc_pkg::t_result r;
        r.heat_relays = heat;
        r.fan_duty    = fan;
        r.heating     = heat;
        r.mode_status = mode;
        r.load_timer  = load;
        r.avg_tenths  = avg;
        return r;
    endfunction

    // advance the thermostat by one command and return the reading it reports
    function automatic htc_pkg::t_result thermo_next(input logic [1:0] cmd,
                                                     input logic [9:0] adc,
                                                     input logic [15:0] remain);
        logic [htc_pkg::TENTHS_W-1:0] scaled;
        int                           avg;
        int                           lowmark;
        logic                         load;
        load = 1'b0;
        case (cmd)
            htc_pkg::CMD_TICK: begin
                // tenths of a degree: floor(adc * 1024 / 450)
                scaled   = htc_pkg::TENTHS_W'((32'(adc) * 1024) / 450);
                ring_sum = ring_sum - htc_pkg::SUM_W'(temp_ring[ring_pos])
                         + htc_pkg::SUM_W'(scaled);
                temp_ring[ring_pos] = scaled;
                ring_pos = ring_pos + 1'b1;
                if (timer_attached) begin
                    if (cooling_down && remain == 0) begin
                        // cooldown over, fan stops
                        fan_level    = htc_pkg::FAN_OFF;
                        cooling_down = 1'b0;
                    end else if (switched_on && remain == 0) begin
                        // run timer expired
                        heat_state   = 1'b0;
                        switched_on  = 1'b0;
                        cooling_down = 1'b1;
                        load         = 1'b1;
                    end else if (switched_on) begin
                        avg     = int'(ring_sum >> htc_pkg::AVG_SHIFT);
                        lowmark = int'(cfg_setpoint) - int'(cfg_hyst);
                        if (avg > int'(cfg_setpoint)) begin
                            heat_state = 1'b0;
                            fan_level  = htc_pkg::FAN_SILENT;
                        end else if (avg <= lowmark) begin
                            heat_state = 1'b1;
                            fan_level  = cfg_turbo ? htc_pkg::FAN_TURBO : htc_pkg::FAN_SILENT;
                        end
                    end
                end
            end
            htc_pkg::CMD_ON: begin
                switched_on    = 1'b1;
                timer_attached = 1'b1;
                cooling_down   = 1'b0;
            end
            htc_pkg::CMD_OFF: begin
                heat_state   = 1'b0;
                switched_on  = 1'b0;
                cooling_down = 1'b1;
                load         = 1'b1;
            end
            default: begin
            end
        endcase
        return reading(heat_state, fan_level,
                       switched_on ? htc_pkg::MODE_ON :
                       (cooling_down ? htc_pkg::MODE_COOL : htc_pkg::MODE_OFF),
                       load, htc_pkg::TENTHS_W'(ring_sum >> htc_pkg::AVG_SHIFT));
    endfunction

    // ------------------------------------------------------------------------
    // receiver: random stalls, plus the long hold-off counted here
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_go != hold_seen) begin
            hold_seen  <= hold_go;
            hold_left  <= HOLD_CYCLES;
            i_m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left  <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // output checker: each beat against the oldest predicted reading
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input int got, input int want,
                               input int beat_no);
        if (got != want)
            report_mismatch($sformatf("beat %0d %s: got %0d, expected %0d",
                                      beat_no, name, got, want));
    endtask

    int out_beats = 0;

    always @(posedge i_clk) begin
        htc_pkg::t_result got;
        htc_pkg::t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = htc_pkg::t_result'(o_m_tdata[24:0]);
            if (readings_due.size() == 0) begin
                report_mismatch($sformatf("beat %0d: output with no reading expected",
                                          out_beats));
            end else begin
                want = readings_due.pop_front();
                check_field("heat_relays", got.heat_relays, want.heat_relays, out_beats);
                check_field("fan_duty",    got.fan_duty,    want.fan_duty,    out_beats);
                check_field("heating",     got.heating,     want.heating,     out_beats);
                check_field("mode_status", got.mode_status, want.mode_status, out_beats);
                check_field("load_timer",  got.load_timer,  want.load_timer,  out_beats);
                check_field("avg_tenths",  got.avg_tenths,  want.avg_tenths,  out_beats);
                check_field("tdata pad",   o_m_tdata[31:25], 0,              out_beats);
            end
            out_beats++;
        end
    end

    // ------------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------------
    // offer one beat, optionally after an idle gap; valid stays high after the
    // handshake so back-to-back beats need no extra edge
    task automatic send_beat(input logic [1:0] cmd, input logic [9:0] adc,
                             input logic [15:0] remain, input bit typed,
                             input htc_pkg::t_result want);
        htc_pkg::t_result predicted;
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= {6'd0, remain, adc};
        do @(posedge i_clk); while (!o_s_tready);
        predicted = thermo_next(cmd, adc, remain);
        // rows typed in by hand take precedence, the model state still moves on
        readings_due.push_back(typed ? want : predicted);
    endtask

    // stop offering and wait until every predicted reading has come out
    task automatic wait_drain();
        i_s_tvalid <= 1'b0;
        while (readings_due.size() != 0) @(posedge i_clk);
    endtask

    // register write over apb, only with the block idle; the bus returns to idle after
    task automatic write_reg(input logic [1:0] idx, input logic [11:0] value);
        wait_drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= htc_pkg::ADDR_W'({idx, 2'b00});
        // junk above the register width must be dropped
        pwdata  <= ({$urandom} << 12) | 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        case (idx)
            htc_pkg::REG_SETPOINT:   cfg_setpoint = value;
            htc_pkg::REG_HYSTERESIS: cfg_hyst     = value[7:0];
            htc_pkg::REG_TURBO:      cfg_turbo    = value[0];
            default: begin
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // directed table
    // ------------------------------------------------------------------------
    t_plan_row dir_plan [DIR_ROWS];

    initial begin
        int      target;
        int      adc_i;
        int      mode_sel;
        logic [1:0] cmd;
        logic [15:0] remain;
        int      pick;

        dir_plan = '{
            // tick before any switch-on, zero timer does nothing
            '{ROW_BEAT, htc_pkg::CMD_TICK,  32'd0,    16'd0,     1'b1,
              reading(1'b0, htc_pkg::FAN_OFF, htc_pkg::MODE_OFF, 1'b0, 12'd0)},
            // full-scale sample: 2327 tenths, average 290
            '{ROW_BEAT, htc_pkg::CMD_TICK,  32'd1023, 16'hFFFF,  1'b1,
              reading(1'b0, htc_pkg::FAN_OFF, htc_pkg::MODE_OFF, 1'b0, 12'd290)},
            // unused command reports state, no load pulse
            '{ROW_BEAT, CMD_SPARE,          32'd1023, 16'hFFFF,  1'b1,
              reading(1'b0, htc_pkg::FAN_OFF, htc_pkg::MODE_OFF, 1'b0, 12'd290)},
            // switch off before any switch-on still enters cooldown
            '{ROW_BEAT, htc_pkg::CMD_OFF,   32'd0,    16'd0,     1'b1,
              reading(1'b0, htc_pkg::FAN_OFF, htc_pkg::MODE_COOL, 1'b1, 12'd290)},
            // no timer attached yet, cooldown tick with zero timer is ignored
            '{ROW_BEAT, htc_pkg::CMD_TICK,  32'd0,    16'd0,     1'b1,
              reading(1'b0, htc_pkg::FAN_OFF, htc_pkg::MODE_COOL, 1'b0, 12'd290)},
            '{ROW_BEAT, htc_pkg::CMD_ON,    32'd0,    16'd0,     1'b1,
              reading(1'b0, htc_pkg::FAN_OFF, htc_pkg::MODE_ON, 1'b0, 12'd290)},
            // over setpoint 0: relays off, fan silent
            '{ROW_BEAT, htc_pkg::CMD_TICK,  32'd0,    16'd100,   1'b1,
              reading(1'b0, htc_pkg::FAN_SILENT, htc_pkg::MODE_ON, 1'b0, 12'd290)},
            '{ROW_REG,  htc_pkg::REG_SETPOINT,   32'd4095, 16'd0, 1'b0, '0},
            '{ROW_REG,  htc_pkg::REG_TURBO,      32'd1,    16'd0, 1'b0, '0},
            // far below setpoint with turbo: heating at full fan
            '{ROW_BEAT, htc_pkg::CMD_TICK,  32'd500,  16'd1000,  1'b0, '0},
            '{ROW_REG,  htc_pkg::REG_HYSTERESIS, 32'd255,  16'd0, 1'b0, '0},
            '{ROW_REG,  htc_pkg::REG_TURBO,      32'd0,    16'd0, 1'b0, '0},
            '{ROW_BEAT, htc_pkg::CMD_TICK,  32'd1023, 16'd7,     1'b0, '0},
            // setpoint 0 with the widest band: low mark goes negative
            '{ROW_REG,  htc_pkg::REG_SETPOINT,   32'd0,    16'd0, 1'b0, '0},
            '{ROW_BEAT, htc_pkg::CMD_TICK,  32'd1023, 16'd1,     1'b0, '0},
            // average walks through the band, below it, back in and above
            '{ROW_REG,  htc_pkg::REG_SETPOINT,   32'd1200, 16'd0, 1'b0, '0},
            '{ROW_BEAT, htc_pkg::CMD_TICK,  32'd0,    16'd50,    1'b0, '0},
            '{ROW_BEAT, htc_pkg::CMD_TICK,  32'd0,    16'd50,    1'b0, '0},
            '{ROW_BEAT, htc_pkg::CMD_TICK,  32'd0,    16'd50,    1'b0, '0},
            '{ROW_BEAT, htc_pkg::CMD_TICK,  32'd1023, 16'd50,    1'b0, '0},
            '{ROW_BEAT, htc_pkg::CMD_TICK,  32'd1023, 16'd50,    1'b0, '0},
            // run timer expiry, then cooldown end, then an idle tick
            '{ROW_BEAT, htc_pkg::CMD_TICK,  32'd512,  16'd0,     1'b0, '0},
            '{ROW_BEAT, htc_pkg::CMD_TICK,  32'd0,    16'd0,     1'b0, '0},
            '{ROW_BEAT, htc_pkg::CMD_TICK,  32'd1023, 16'd0,     1'b0, '0},
            // switch off while already off, then on and off again
            '{ROW_BEAT, htc_pkg::CMD_OFF,   32'd0,    16'd0,     1'b0, '0},
            '{ROW_BEAT, htc_pkg::CMD_ON,    32'd1023, 16'hFFFF,  1'b0, '0},
            '{ROW_BEAT, htc_pkg::CMD_TICK,  32'd300,  16'd2,     1'b0, '0},
            '{ROW_BEAT, htc_pkg::CMD_OFF,   32'd1023, 16'hFFFF,  1'b0, '0}
        };

        // single reset at the start of the run
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            if (dir_plan[r].kind == ROW_REG)
                write_reg(dir_plan[r].code, dir_plan[r].value[11:0]);
            else
                send_beat(dir_plan[r].code, dir_plan[r].value[9:0], dir_plan[r].remain,
                          dir_plan[r].typed, dir_plan[r].want);
        end

        // --------------------------------------------------------------------
        // random phases: register setting and idling change per phase
        // --------------------------------------------------------------------
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == 0) begin
                write_reg(htc_pkg::REG_SETPOINT, 12'd0);
                write_reg(htc_pkg::REG_HYSTERESIS, 12'd0);
                write_reg(htc_pkg::REG_TURBO, 12'd1);
            end else if (ph == 1) begin
                write_reg(htc_pkg::REG_SETPOINT, 12'd4095);
                write_reg(htc_pkg::REG_HYSTERESIS, 12'd255);
                write_reg(htc_pkg::REG_TURBO, 12'd0);
            end else begin
                // setpoints mostly inside the reachable range of the average
                write_reg(htc_pkg::REG_SETPOINT, 12'($urandom_range(2400)));
                write_reg(htc_pkg::REG_HYSTERESIS, 12'($urandom_range(255)));
                write_reg(htc_pkg::REG_TURBO, 12'($urandom_range(1)));
            end

            // no idling, sender idle, receiver stalling, both lightly
            mode_sel = ph % 4;
            src_idle_pct  = (mode_sel == 1) ? 83 : (mode_sel == 3) ? 13 : 0;
            snk_stall_pct <= (mode_sel == 2) ? 83 : (mode_sel == 3) ? 13 : 0;

            target = $urandom_range(1023);
            for (int k = 0; k < PHASE_BEATS; k++) begin
                // long receiver hold-off while beats keep coming, fills the pipe
                if (ph == 0 && k == 40)
                    hold_go <= ~hold_go;
                // sender pauses until every reading is out
                if (ph == 5 && k == PHASE_BEATS / 2)
                    wait_drain();

                // samples cluster around a drifting level so the average crosses
                // the band; some are spread over the full scale
                if (k % 16 == 0)
                    target = $urandom_range(1023);
                if ($urandom_range(4) == 0) begin
                    adc_i = $urandom_range(1023);
                end else begin
                    adc_i = target - 60 + $urandom_range(120);
                    if (adc_i < 0)    adc_i = 0;
                    if (adc_i > 1023) adc_i = 1023;
                end

                // mostly ticks with time left; expiries, on and off spread in
                pick = $urandom_range(99);
                if (pick < 6)
                    cmd = htc_pkg::CMD_ON;
                else if (pick < 10)
                    cmd = htc_pkg::CMD_OFF;
                else if (pick < 12)
                    cmd = CMD_SPARE;
                else
                    cmd = htc_pkg::CMD_TICK;
                remain = ($urandom_range(99) < 8) ? 16'd0 : 16'($urandom_range(65535));

                send_beat(cmd, 10'(adc_i), remain, 1'b0, '0);
            end
        end

        // --------------------------------------------------------------------
        // wind down: all readings out, then a quiet wait for strays
        // --------------------------------------------------------------------
        wait_drain();
        src_idle_pct  = 0;
        snk_stall_pct <= 0;
        repeat (10) @(posedge i_clk);

        if (mismatch_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // hard limit, far above the slowest correct run
    initial begin
        #(5_000_000);
        $display("ERROR: timeout with %0d readings outstanding", readings_due.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
